// ----- src/pts_pkg.sv -----
// shared types, codes and constants of the periodic task scheduler
`default_nettype none
package pts_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int PERIOD_W  = 32;
    localparam int TIME_W    = 64;
    localparam int BLOCK_W   = 32;
    localparam int CFG_W     = 16;
    localparam int SLOT_IN_W = 4;
    localparam int OCC_OUT_W = 5;
    localparam int OP_W      = 3;
    localparam int WORD_W    = 2 * PERIOD_W;

    // stream layout
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 80;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCKING_LIMIT   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REFRESH_INTERVAL = 1'd1;

    localparam logic [CFG_W-1:0] BLOCKING_LIMIT_RST   = 16'd8;
    localparam logic [CFG_W-1:0] REFRESH_INTERVAL_RST = 16'd40;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_SCHEDULE = 3'd1,
        OP_DELETE   = 3'd2,
        OP_DISPATCH = 3'd3,
        OP_FINISH   = 3'd4,
        OP_SET_TIME = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        SL_FREE    = 3'd0,
        SL_STOPPED = 3'd1,
        SL_WAITING = 3'd2,
        SL_READY   = 3'd3,
        SL_RUNNING = 3'd4
    } slot_st_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_TICK,
        FS_SCHED,
        FS_DISP,
        FS_OUT
    } fsm_t;

    typedef enum logic [1:0] {
        SK_WAIT,
        SK_FREE,
        SK_READY
    } scan_kind_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic tick_proc;
        logic sched_chk;
        logic disp_chk;
        logic load_out;
    } ctl_t;

endpackage
`default_nettype wire

// ----- src/pts_slot_ram.sv -----
// period and counter store of the task slots, one write and one registered read port
`default_nettype none
module pts_slot_ram #(
    parameter int DEPTH = pts_pkg::SLOTS_DEFAULT,
    parameter int AW    = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [pts_pkg::WORD_W-1:0] wdata,
    input  wire logic [AW-1:0]             raddr,
    output logic      [pts_pkg::WORD_W-1:0] rdata
);
    import pts_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- src/pts_slot_unit.sv -----
// shared slot examine unit: state match, period compare and counter step
`default_nettype none
module pts_slot_unit (
    input  wire pts_pkg::scan_kind_t         kind,
    input  wire pts_pkg::slot_st_t           st,
    input  wire logic [pts_pkg::PERIOD_W-1:0] ctr,
    input  wire logic [pts_pkg::PERIOD_W-1:0] per,
    output logic                             hit,
    output logic                             expire,
    output logic      [pts_pkg::PERIOD_W-1:0] ctr_new
);
    import pts_pkg::*;

    always_comb begin
        case (kind)
            SK_FREE:  hit = (st == SL_FREE);
            SK_READY: hit = (st == SL_READY);
            SK_WAIT:  hit = (st == SL_WAITING);
            default:  hit = 1'b0;
        endcase
    end

    assign expire  = (ctr == per - PERIOD_W'(1));
    assign ctr_new = expire ? '0 : ctr + PERIOD_W'(1);

endmodule
`default_nettype wire

// ----- src/pts_ctrl.sv -----
// sequencer: operation decode, slot walk counters and result hand-off
`default_nettype none
module pts_ctrl #(
    parameter int SLOTS = pts_pkg::SLOTS_DEFAULT,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire pts_pkg::op_t     in_op,
    input  wire logic             hit,
    input  wire logic             out_free,
    input  wire logic [IW-1:0]    scan_ptr,
    output pts_pkg::ctl_t         ctl,
    output logic      [IW-1:0]    pos,
    output logic      [IW-1:0]    pos_d
);
    import pts_pkg::*;

    fsm_t            state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic [IW-1:0]   pos_d_reg;
    logic [IW-1:0]   pos_inc;
    logic            walk_end;

    assign pos_inc  = (pos_reg == IW'(SLOTS - 1)) ? '0 : pos_reg + IW'(1);
    assign walk_end = (cnt_reg == CW'(SLOTS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE: begin
                if (in_valid) begin
                    case (in_op)
                        OP_TICK:     state_next = FS_TICK;
                        OP_SCHEDULE: state_next = FS_SCHED;
                        OP_DISPATCH: state_next = FS_DISP;
                        default:     state_next = FS_OUT;
                    endcase
                end
            end
            FS_TICK: begin
                if (cnt_reg == CW'(SLOTS)) state_next = FS_OUT;
            end
            FS_SCHED, FS_DISP: begin
                if (hit || walk_end) state_next = FS_OUT;
            end
            FS_OUT: begin
                if (out_free) state_next = FS_IDLE;
            end
            default: state_next = FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctl = '0;
        case (state_reg)
            FS_IDLE: begin
                ctl.ready  = 1'b1;
                ctl.accept = in_valid;
            end
            FS_TICK:  ctl.tick_proc = (cnt_reg != '0);
            FS_SCHED: ctl.sched_chk = 1'b1;
            FS_DISP:  ctl.disp_chk  = 1'b1;
            FS_OUT:   ctl.load_out  = out_free;
            default:  ctl = '0;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (ctl.accept) begin
            cnt_next = '0;
            pos_next = (in_op == OP_DISPATCH) ? scan_ptr : '0;
        end else if (state_reg == FS_TICK || state_reg == FS_SCHED
                     || state_reg == FS_DISP) begin
            cnt_next = cnt_reg + CW'(1);
            pos_next = pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
            cnt_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_d_reg <= pos_reg;
    end

    assign pos   = pos_reg;
    assign pos_d = pos_d_reg;

endmodule
`default_nettype wire

// ----- src/periodic_task_scheduler_core.sv -----
// top level of the periodic task scheduler: slot table, timers and stream ports
// operations: a tick walks the whole slot table, updating each waiting slot in turn
// schedule and dispatch search the table one slot per cycle and stop at the first hit
// delete, finish, set time and unused codes need no walk; next transaction taken once idle
// one operation at a time: its result is handed off before the next is accepted
// reset: synchronous active-low aresetn frees all slots and clears timers and pointer
`default_nettype none
module periodic_task_scheduler_core #(
    parameter int SLOTS = pts_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration writes
    input  wire logic                          cfg_wr_en,
    input  wire logic [pts_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [pts_pkg::CFG_W-1:0]      cfg_wdata,
    // operation transactions
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // period[31:0], start_running[32], slot[36:33], new_time[100:37], zero pad
    input  wire logic [pts_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  wire logic [pts_pkg::OP_W-1:0]       s_tuser,
    // result transactions
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // result_slot[3:0], found[4], occupied_count[9:5], time_count[73:10],
    // reset_request[74], watchdog_refresh[75], zero pad
    output logic      [pts_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pts_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // input field split
    op_t                    in_op;
    logic [PERIOD_W-1:0]    in_period;
    logic                   in_start;
    logic [SLOT_IN_W-1:0]   in_slot;
    logic [TIME_W-1:0]      in_new_time;
    logic                   in_range;

    assign in_op       = op_t'(s_tuser);
    assign in_period   = s_tdata[31:0];
    assign in_start    = s_tdata[32];
    assign in_slot     = s_tdata[36:33];
    assign in_new_time = s_tdata[100:37];
    assign in_range    = ({3'b000, in_slot} < 7'(SLOTS));

    // configuration registers
    logic [CFG_W-1:0] blocking_limit_reg;
    logic [CFG_W-1:0] refresh_interval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocking_limit_reg   <= BLOCKING_LIMIT_RST;
            refresh_interval_reg <= REFRESH_INTERVAL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BLOCKING_LIMIT:   blocking_limit_reg   <= cfg_wdata;
                CFG_REFRESH_INTERVAL: refresh_interval_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    ctl_t           ctl;
    logic [IW-1:0]  pos;
    logic [IW-1:0]  pos_d;
    logic           hit;
    logic           out_free;
    logic           m_tvalid_reg;
    logic [IW-1:0]  scan_ptr_reg, scan_ptr_next;

    assign out_free = !m_tvalid_reg || m_tready;

    pts_ctrl #(
        .SLOTS (SLOTS),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (in_op),
        .hit      (hit),
        .out_free (out_free),
        .scan_ptr (scan_ptr_reg),
        .ctl      (ctl),
        .pos      (pos),
        .pos_d    (pos_d)
    );

    assign s_tready = ctl.ready;

    // slot state table, one address per cycle: the accepted slot, the tick
    // slot whose counter word has just been read, or the search position
    slot_st_t       slot_state_reg [SLOTS];
    logic [IW-1:0]  st_addr;
    slot_st_t       cur_st;
    logic           st_we;
    slot_st_t       st_wdata;

    assign st_addr = ctl.accept ? IW'(in_slot) : (ctl.tick_proc ? pos_d : pos);
    assign cur_st  = slot_state_reg[st_addr];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_state_reg[i] <= SL_FREE;
            end
        end else if (st_we) begin
            slot_state_reg[st_addr] <= st_wdata;
        end
    end

    // period and counter words, read one slot ahead during a tick walk
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [WORD_W-1:0]    mem_rdata;
    logic [PERIOD_W-1:0]  per_rd;
    logic [PERIOD_W-1:0]  ctr_rd;

    assign per_rd = mem_rdata[WORD_W-1:PERIOD_W];
    assign ctr_rd = mem_rdata[PERIOD_W-1:0];

    pts_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (pos),
        .rdata (mem_rdata)
    );

    // shared examine unit
    scan_kind_t           kind;
    logic                 expire;
    logic [PERIOD_W-1:0]  ctr_new;

    assign kind = ctl.sched_chk ? SK_FREE : (ctl.disp_chk ? SK_READY : SK_WAIT);

    pts_slot_unit u_slot_unit (
        .kind    (kind),
        .st      (cur_st),
        .ctr     (ctr_rd),
        .per     (per_rd),
        .hit     (hit),
        .expire  (expire),
        .ctr_new (ctr_new)
    );

    // scheduling state
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [BLOCK_W-1:0]   block_reg, block_next;
    logic [CFG_W-1:0]     refresh_reg, refresh_next;
    logic [CW-1:0]        occ_reg, occ_next;
    logic [CW-1:0]        run_reg, run_next;
    logic [SLOT_IN_W-1:0] res_slot_reg, res_slot_next;
    logic                 found_reg, found_next;
    logic                 rst_req_reg, rst_req_next;
    logic                 wdr_reg, wdr_next;
    logic [PERIOD_W-1:0]  per_reg;
    logic                 start_reg;
    logic [IW-1:0]        pos_wrap;

    assign pos_wrap = (pos == IW'(SLOTS - 1)) ? '0 : pos + IW'(1);

    always_comb begin
        logic [CFG_W-1:0] refresh_inc;
        refresh_inc   = refresh_reg + CFG_W'(1);
        time_next     = time_reg;
        block_next    = block_reg;
        refresh_next  = refresh_reg;
        occ_next      = occ_reg;
        run_next      = run_reg;
        scan_ptr_next = scan_ptr_reg;
        res_slot_next = res_slot_reg;
        found_next    = found_reg;
        rst_req_next  = rst_req_reg;
        wdr_next      = wdr_reg;
        st_we         = 1'b0;
        st_wdata      = cur_st;
        mem_we        = 1'b0;
        mem_waddr     = pos;
        mem_wdata     = {per_rd, ctr_new};

        if (ctl.accept) begin
            res_slot_next = '0;
            found_next    = 1'b0;
            rst_req_next  = 1'b0;
            wdr_next      = 1'b0;
            case (in_op)
                OP_TICK: begin
                    time_next = time_reg + TIME_W'(1);
                    // blocking count only advances while some task runs
                    if (run_reg != '0) begin
                        rst_req_next = (block_reg > BLOCK_W'(blocking_limit_reg));
                        if (block_reg != '1) block_next = block_reg + BLOCK_W'(1);
                    end else begin
                        block_next = '0;
                    end
                    if (refresh_inc == refresh_interval_reg) begin
                        refresh_next = '0;
                        wdr_next     = 1'b1;
                    end else begin
                        refresh_next = refresh_inc;
                    end
                end
                OP_DELETE: begin
                    if (in_range) begin
                        st_we    = 1'b1;
                        st_wdata = SL_FREE;
                        if (cur_st != SL_FREE)    occ_next = occ_reg - CW'(1);
                        if (cur_st == SL_RUNNING) run_next = run_reg - CW'(1);
                    end
                end
                OP_FINISH: begin
                    if (in_range && cur_st == SL_RUNNING) begin
                        st_we      = 1'b1;
                        st_wdata   = SL_WAITING;
                        run_next   = run_reg - CW'(1);
                        block_next = '0;
                    end
                end
                OP_SET_TIME: time_next = in_new_time;
                default: ;
            endcase
        end else if (ctl.tick_proc) begin
            // waiting slot: count up, or turn ready and restart at period end
            if (hit) begin
                st_we     = 1'b1;
                st_wdata  = expire ? SL_READY : SL_WAITING;
                mem_we    = 1'b1;
                mem_waddr = pos_d;
            end
        end else if (ctl.sched_chk) begin
            if (hit) begin
                st_we         = 1'b1;
                st_wdata      = start_reg ? SL_WAITING : SL_STOPPED;
                mem_we        = 1'b1;
                mem_wdata     = {per_reg, {PERIOD_W{1'b0}}};
                occ_next      = occ_reg + CW'(1);
                res_slot_next = SLOT_IN_W'(pos);
                found_next    = 1'b1;
            end
        end else if (ctl.disp_chk) begin
            if (hit) begin
                st_we         = 1'b1;
                st_wdata      = SL_RUNNING;
                run_next      = run_reg + CW'(1);
                scan_ptr_next = pos_wrap;
                block_next    = '0;
                res_slot_next = SLOT_IN_W'(pos);
                found_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg     <= '0;
            block_reg    <= '0;
            refresh_reg  <= '0;
            occ_reg      <= '0;
            run_reg      <= '0;
            scan_ptr_reg <= '0;
            res_slot_reg <= '0;
            found_reg    <= 1'b0;
            rst_req_reg  <= 1'b0;
            wdr_reg      <= 1'b0;
        end else begin
            time_reg     <= time_next;
            block_reg    <= block_next;
            refresh_reg  <= refresh_next;
            occ_reg      <= occ_next;
            run_reg      <= run_next;
            scan_ptr_reg <= scan_ptr_next;
            res_slot_reg <= res_slot_next;
            found_reg    <= found_next;
            rst_req_reg  <= rst_req_next;
            wdr_reg      <= wdr_next;
        end
    end

    // schedule arguments, zero period stored as one
    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            per_reg   <= (in_period == '0) ? PERIOD_W'(1) : in_period;
            start_reg <= in_start;
        end
    end

    // result register
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            m_tdata_reg <= {4'b0000, wdr_reg, rst_req_reg, time_reg,
                            OCC_OUT_W'(occ_reg), found_reg, res_slot_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // running slots are a subset of occupied ones
    a_run_le_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= occ_reg)
        else $error("running count above occupied count");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CW'(SLOTS))
        else $error("occupied count above slot count");

    // an operation owns the block until its result is handed off
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("transaction taken while an operation is in flight");

    a_found_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.load_out && found_reg) |-> ({3'b000, res_slot_reg} < 7'(SLOTS)))
        else $error("reported slot outside the table");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/periodic_task_scheduler_checker.sv -----
// watches the scheduler's stream and config ports, predicts each result and compares it
`timescale 1ns / 1ps
module periodic_task_scheduler_checker #(
    parameter int SLOTS = pts_pkg::SLOTS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [pts_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [pts_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [pts_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [pts_pkg::OP_W-1:0]       s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [pts_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                                  mismatches,
    output int                                  outstanding
);
    import pts_pkg::*;

    typedef struct {
        logic [3:0]  result_slot;
        logic        found;
        logic [4:0]  occupied;
        logic [63:0] time_count;
        logic        reset_request;
        logic        watchdog_refresh;
    } sched_result_t;

    sched_result_t result_queue [$];

    // mirror of the slot table and timers
    slot_st_t          task_state  [SLOTS];
    logic [31:0]       task_count  [SLOTS];
    logic [31:0]       task_period [SLOTS];
    int unsigned       scan_ptr;
    logic [63:0]       now_ticks;
    logic [31:0]       hold_ticks;
    logic [15:0]       wd_count;
    logic [CFG_W-1:0]  blocking_limit;
    logic [CFG_W-1:0]  refresh_interval;

    function automatic sched_result_t run_operation(logic [OP_W-1:0] op_code,
                                                    logic [31:0] period, logic start,
                                                    logic [3:0] slot_idx,
                                                    logic [63:0] new_time);
        sched_result_t r;
        bit            running;
        bit            done;
        int unsigned   p;
        int            occ;
        r = '{default: '0};
        running = 0;
        done = 0;
        occ = 0;
        case (op_code)
            OP_TICK: begin
                now_ticks = now_ticks + 64'd1;
                for (int i = 0; i < SLOTS; i++)
                    if (task_state[i] == SL_RUNNING) running = 1;
                if (running) begin
                    if (hold_ticks > {16'd0, blocking_limit}) r.reset_request = 1'b1;
                    if (hold_ticks != '1) hold_ticks = hold_ticks + 32'd1;
                end else begin
                    hold_ticks = '0;
                end
                wd_count = wd_count + 16'd1;
                if (wd_count == refresh_interval) begin
                    wd_count = '0;
                    r.watchdog_refresh = 1'b1;
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (task_state[i] == SL_WAITING) begin
                        if (task_count[i] == task_period[i] - 32'd1) begin
                            task_count[i] = '0;
                            task_state[i] = SL_READY;
                        end else begin
                            task_count[i] = task_count[i] + 32'd1;
                        end
                    end
                end
            end
            OP_SCHEDULE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && task_state[i] == SL_FREE) begin
                        task_count[i] = '0;
                        task_period[i] = (period == '0) ? 32'd1 : period;
                        task_state[i] = start ? SL_WAITING : SL_STOPPED;
                        r.result_slot = 4'(i);
                        r.found = 1'b1;
                        done = 1;
                    end
                end
            end
            OP_DELETE: begin
                if (int'(slot_idx) < SLOTS) task_state[slot_idx] = SL_FREE;
            end
            OP_DISPATCH: begin
                p = scan_ptr % SLOTS;
                for (int k = 0; k < SLOTS; k++) begin
                    if (!done) begin
                        if (task_state[p] == SL_READY) begin
                            task_state[p] = SL_RUNNING;
                            r.result_slot = 4'(p);
                            r.found = 1'b1;
                            scan_ptr = (p + 1) % SLOTS;
                            hold_ticks = '0;
                            done = 1;
                        end else begin
                            p = (p + 1) % SLOTS;
                        end
                    end
                end
            end
            OP_FINISH: begin
                if (int'(slot_idx) < SLOTS && task_state[slot_idx] == SL_RUNNING) begin
                    task_state[slot_idx] = SL_WAITING;
                    hold_ticks = '0;
                end
            end
            OP_SET_TIME: now_ticks = new_time;
            default: ;
        endcase
        for (int i = 0; i < SLOTS; i++)
            if (task_state[i] != SL_FREE) occ++;
        r.occupied = 5'(occ);
        r.time_count = now_ticks;
        return r;
    endfunction

    task automatic compare_field(string label, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        sched_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                task_state[i] = SL_FREE;
                task_count[i] = '0;
                task_period[i] = '0;
            end
            scan_ptr = 0;
            now_ticks = '0;
            hold_ticks = '0;
            wd_count = '0;
            blocking_limit = BLOCKING_LIMIT_RST;
            refresh_interval = REFRESH_INTERVAL_RST;
            result_queue.delete();
            mismatches = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_BLOCKING_LIMIT:   blocking_limit = cfg_wdata;
                    CFG_REFRESH_INTERVAL: refresh_interval = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %0h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = result_queue.pop_front();
                    compare_field("result_slot", 64'(want.result_slot), 64'(m_tdata[3:0]));
                    compare_field("found", 64'(want.found), 64'(m_tdata[4]));
                    compare_field("occupied_count", 64'(want.occupied), 64'(m_tdata[9:5]));
                    compare_field("time_count", want.time_count, m_tdata[73:10]);
                    compare_field("reset_request", 64'(want.reset_request), 64'(m_tdata[74]));
                    compare_field("watchdog_refresh", 64'(want.watchdog_refresh),
                                  64'(m_tdata[75]));
                end
            end
            if (s_tvalid && s_tready)
                result_queue.push_back(run_operation(s_tuser, s_tdata[31:0], s_tdata[32],
                                                     s_tdata[36:33], s_tdata[100:37]));
        end
        outstanding <= result_queue.size();
    end

endmodule

// ----- tb/sv/periodic_task_scheduler_core_tb.sv -----
// stimulus, clock, reset and verdict for the periodic task scheduler core
`timescale 1ns / 1ps
module periodic_task_scheduler_core_tb;
    import pts_pkg::*;

    localparam int SLOTS         = SLOTS_DEFAULT;
    localparam int CLK_PERIOD    = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // a tick walks the whole table, so let it finish before touching config
    localparam int SETTLE_CYCLES = SLOTS + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 220;

    // idle profiles
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    // operation codes the block has no meaning for
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // period[31:0], start_running[32], slot[36:33], new_time[100:37], zero pad
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    // operation[2:0]
    logic [OP_W-1:0]        s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // result_slot[3:0], found[4], occupied_count[9:5], time_count[73:10],
    // reset_request[74], watchdog_refresh[75], zero pad
    logic [M_TDATA_W-1:0]   m_tdata;

    int mismatches;
    int outstanding;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // long receiver hold-off: stimulus bumps the request, receiver side counts it out
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    periodic_task_scheduler_core #(.SLOTS(SLOTS)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    periodic_task_scheduler_checker #(.SLOTS(SLOTS)) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random back-pressure, or a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // offer one operation transaction, with random idle cycles ahead of it
    task automatic issue_op(logic [OP_W-1:0] op_code, logic [31:0] period, logic start,
                            logic [3:0] slot_idx, logic [63:0] new_time);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[31:0]   = period;
        word[32]     = start;
        word[36:33]  = slot_idx;
        word[100:37] = new_time;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op_code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // sender pauses until every expected result is back, then lets the block settle
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both registers in back-to-back cycles; only called with the block idle
    task automatic set_regs(logic [CFG_W-1:0] block_lim, logic [CFG_W-1:0] refresh_ivl);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_BLOCKING_LIMIT;
        cfg_wdata <= block_lim;
        @(posedge aclk);
        cfg_addr  <= CFG_REFRESH_INTERVAL;
        cfg_wdata <= refresh_ivl;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // operation mix: a fill profile packs the table, the churn profile cycles tasks through
    function automatic logic [OP_W-1:0] pick_op(bit fill_mode);
        op_t         order [6];
        int unsigned bound [6];
        int unsigned r;
        order = '{OP_TICK, OP_SCHEDULE, OP_DELETE, OP_DISPATCH, OP_FINISH, OP_SET_TIME};
        if (fill_mode) bound = '{30, 65, 68, 85, 95, 97};
        else           bound = '{38, 50, 59, 79, 93, 97};
        r = $urandom_range(0, 99);
        for (int k = 0; k < 6; k++)
            if (r < bound[k]) return order[k];
        return ($urandom_range(0, 1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
    endfunction

    task automatic issue_random_op(bit fill_mode);
        logic [OP_W-1:0] op_code;
        logic [31:0]     period;
        logic            start;
        logic [3:0]      slot_idx;
        logic [63:0]     new_time;
        int unsigned     r;
        op_code = pick_op(fill_mode);
        // short periods so tasks come ready often; a few huge ones park in the table
        r = $urandom_range(0, 15);
        if (r == 0)      period = $urandom;
        else if (r == 1) period = '0;
        else if (r < 4)  period = $urandom_range(6, 40);
        else             period = $urandom_range(1, 5);
        start = ($urandom_range(0, 9) != 0);
        // low slots are where the tasks live most of the time
        if ($urandom_range(0, 3) != 0) slot_idx = 4'($urandom_range(0, 7));
        else                           slot_idx = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 2);
        if (r == 0)      new_time = {$urandom, $urandom};
        else if (r == 1) new_time = 64'($urandom_range(0, 1000));
        else             new_time = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
        issue_op(op_code, period, start, slot_idx, new_time);
    endtask

    initial begin
        logic [CFG_W-1:0] block_lim;
        logic [CFG_W-1:0] refresh_ivl;
        int               idle_mode;
        bit               fill_mode;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // tight limits so the directed run shows reset requests and refresh pulses quickly
        set_regs(16'd1, 16'd2);

        // time count wraps from all ones
        issue_op(OP_SET_TIME, '0, 1'b0, 4'd0, '1);
        issue_op(OP_TICK, '0, 1'b0, 4'd0, '0);
        // zero period turns into one, all-ones period parked as stopped
        issue_op(OP_SCHEDULE, 32'd0, 1'b1, 4'd0, '0);
        issue_op(OP_SCHEDULE, '1, 1'b0, 4'd0, '0);
        issue_op(OP_SCHEDULE, 32'd2, 1'b1, 4'd0, '0);
        // nothing ready yet
        issue_op(OP_DISPATCH, '0, 1'b0, 4'd0, '0);
        issue_op(OP_TICK, '0, 1'b0, 4'd0, '0);
        issue_op(OP_TICK, '0, 1'b0, 4'd0, '0);
        // round-robin hands out both ready slots, then finds none
        issue_op(OP_DISPATCH, '0, 1'b0, 4'd0, '0);
        issue_op(OP_DISPATCH, '0, 1'b0, 4'd0, '0);
        issue_op(OP_DISPATCH, '0, 1'b0, 4'd0, '0);
        // running tasks held past the blocking limit
        repeat (3) issue_op(OP_TICK, '0, 1'b0, 4'd0, '0);
        // finish on running, then on a stopped slot which stays put
        issue_op(OP_FINISH, '0, 1'b0, 4'd0, '0);
        issue_op(OP_FINISH, '0, 1'b0, 4'd1, '0);
        // delete a running slot and a slot that is already free
        issue_op(OP_DELETE, '0, 1'b0, 4'd2, '0);
        issue_op(OP_TICK, '0, 1'b0, 4'd0, '0);
        issue_op(OP_DELETE, '0, 1'b0, 4'd15, '0);
        // unused codes change nothing; then the time count is set back to zero
        issue_op(OP_UNUSED_LO, $urandom, 1'b1, 4'd9, {$urandom, $urandom});
        issue_op(OP_UNUSED_HI, '1, 1'b1, 4'd15, '1);
        issue_op(OP_SET_TIME, '1, 1'b1, 4'd15, '0);
        // every field at all ones on a schedule
        issue_op(OP_SCHEDULE, '1, 1'b1, 4'd15, '1);
        issue_op(OP_DELETE, '0, 1'b0, 4'd1, '0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin block_lim = 16'd8;    refresh_ivl = 16'd40;
                               idle_mode = IDLE_NONE;     fill_mode = 0; end
                1:       begin block_lim = 16'd0;    refresh_ivl = 16'd1;
                               idle_mode = IDLE_SENDER;   fill_mode = 1; end
                2:       begin block_lim = 16'hFFFF; refresh_ivl = 16'hFFFF;
                               idle_mode = IDLE_RECEIVER; fill_mode = 0; end
                3:       begin block_lim = 16'd2;    refresh_ivl = 16'd3;
                               idle_mode = IDLE_BOTH;     fill_mode = 0; end
                4:       begin block_lim = 16'd5;    refresh_ivl = 16'd0;
                               idle_mode = IDLE_NONE;     fill_mode = 1; end
                5:       begin block_lim = 16'd1;    refresh_ivl = 16'd7;
                               idle_mode = IDLE_SENDER;   fill_mode = 0; end
                6:       begin block_lim = 16'd3;    refresh_ivl = 16'd2;
                               idle_mode = IDLE_RECEIVER; fill_mode = 0; end
                default: begin block_lim = 16'd4;    refresh_ivl = 16'd1;
                               idle_mode = IDLE_BOTH;     fill_mode = 1; end
            endcase
            set_regs(block_lim, refresh_ivl);
            tx_idle_pct  <= (idle_mode == IDLE_SENDER)   ? 72 :
                            (idle_mode == IDLE_BOTH)     ? 6  : 0;
            rx_stall_pct <= (idle_mode == IDLE_RECEIVER) ? 72 :
                            (idle_mode == IDLE_BOTH)     ? 6  : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mid-phase the receiver holds off while the sender keeps offering
                if (ph == 3 && n == PHASE_ITEMS / 2) hold_req <= hold_req + 1;
                issue_random_op(fill_mode);
            end
            drain();
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
